### src/cecb_pkg.sv
// ----------------------------------------------------------------------------
// cecb_pkg
// Shared types, constants and the linearization table builder for the
// contrast enforcing color blend.
// ----------------------------------------------------------------------------
`default_nettype none

package cecb_pkg;

   // Channel and table geometry
   localparam int CH_BITS        = 16;
   localparam int LUT_INDEX_BITS = 10;
   localparam int LUT_SIZE       = 1 << LUT_INDEX_BITS;
   localparam int LUT_SHIFT      = CH_BITS - LUT_INDEX_BITS;
   localparam longint unsigned LUT_MAX = LUT_SIZE - 1;

   // Luminance and contrast constants
   localparam logic [16:0] LUM_OFFSET = 17'd3277;
   localparam logic [33:0] TEXT_LIMIT = 34'd225485783;
   localparam logic [16:0] W_RED      = 17'd13933;
   localparam logic [16:0] W_GREEN    = 17'd46871;
   localparam logic [16:0] W_BLUE     = 17'd4732;

   // Configuration register indexes
   localparam logic [1:0] CSR_MIN_CONTRAST = 2'd0;
   localparam logic [1:0] CSR_BLEND_AMOUNT = 2'd1;
   localparam logic [1:0] CSR_MAX_STEPS    = 2'd2;

   localparam logic [14:0] MIN_CONTRAST_RST = 15'd12288;
   localparam logic [15:0] BLEND_AMOUNT_RST = 16'd3932;
   localparam logic [5:0]  MAX_STEPS_RST    = 6'd20;

   // Channel select codes
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   typedef logic [15:0] lin_table_type [LUT_SIZE];

   typedef struct packed {
      logic [7:0] accent_red;
      logic [7:0] accent_green;
      logic [7:0] accent_blue;
      logic [7:0] back_red;
      logic [7:0] back_green;
      logic [7:0] back_blue;
      logic       dark_mode;
   } req_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BK_RD,
      ST_BK_MAC,
      ST_AC_RD,
      ST_AC_MAC,
      ST_CMP_MUL,
      ST_DECIDE,
      ST_BLEND,
      ST_TXT,
      ST_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic       load;
      logic       rd;
      logic       mac;
      logic       use_back;
      logic [1:0] chan;
      logic       cmp_mul;
      logic       finish;
      logic       blend;
      logic       step_inc;
      logic       txt;
      logic       out_load;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic below;
      logic more_steps;
      logic out_busy;
   } dp_status_type;

   function automatic logic [16:0] lum_weight(input logic [1:0] chan);
      logic [16:0] w;
      case (chan)
         CH_RED:   w = W_RED;
         CH_GREEN: w = W_GREEN;
         CH_BLUE:  w = W_BLUE;
         default:  w = '0;
      endcase
      return w;
   endfunction

   // sRGB to linear, Q0.16 in and out; fifth root found by bisection
   function automatic lin_table_type build_lin_table();
      lin_table_type    tbl;
      longint unsigned  x, t, tt, n, lo, hi, mid, p, r;
      for (int i = 0; i < LUT_SIZE; i++) begin
         x = (longint'(i) * 65535) / LUT_MAX;
         if (x <= 2574) begin
            r = (x * 100) / 1292;
         end else begin
            t  = (1000 * x + 3604480) / 1055;
            tt = t >> 2;
            n  = (tt * tt) << 32;
            lo = 0;
            hi = 4096;
            for (int s = 0; s < 16; s++) begin
               if (lo < hi) begin
                  mid = (lo + hi + 1) >> 1;
                  p   = mid * mid * mid * mid * mid;
                  if (p <= n) lo = mid;
                  else        hi = mid - 1;
               end
            end
            r = (t * t * lo) >> 28;
         end
         tbl[i] = r[15:0];
      end
      return tbl;
   endfunction

endpackage

`default_nettype wire

### src/cecb_if.sv
// ----------------------------------------------------------------------------
// cecb interfaces
// Request, response and register write channels, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface cecb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] accent_red;
   logic [7:0] accent_green;
   logic [7:0] accent_blue;
   logic [7:0] back_red;
   logic [7:0] back_green;
   logic [7:0] back_blue;
   logic       dark_mode;
   modport source (output valid, accent_red, accent_green, accent_blue,
                   back_red, back_green, back_blue, dark_mode, input ready);
   modport sink   (input valid, accent_red, accent_green, accent_blue,
                   back_red, back_green, back_blue, dark_mode, output ready);
endinterface

interface cecb_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] sel_red;
   logic [15:0] sel_green;
   logic [15:0] sel_blue;
   logic        text_is_black;
   logic [5:0]  blend_steps;
   logic        contrast_met;
   modport source (output valid, sel_red, sel_green, sel_blue, text_is_black,
                   blend_steps, contrast_met, input ready);
   modport sink   (input valid, sel_red, sel_green, sel_blue, text_is_black,
                   blend_steps, contrast_met, output ready);
endinterface

interface cecb_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/cecb_ctrl.sv
// ----------------------------------------------------------------------------
// cecb_ctrl
// Sequencer: luminance passes, contrast check, blend steps, text choice.
// ----------------------------------------------------------------------------
`default_nettype none

module cecb_ctrl
   import cecb_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_ready,
   input  wire dp_status_type status,
   output      dp_cmd_type    cmd
);

   state_type  state_ff, state_in;
   logic [1:0] chan_ff, chan_in;
   logic       last_chan;

   assign last_chan = (chan_ff == CH_BLUE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chan_ff  <= CH_RED;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      chan_in  = chan_ff;
      unique case (state_ff)
         ST_IDLE: begin
            chan_in = CH_RED;
            if (req_valid) state_in = ST_BK_RD;
         end
         ST_BK_RD:  state_in = ST_BK_MAC;
         ST_BK_MAC: begin
            state_in = last_chan ? ST_AC_RD : ST_BK_RD;
            chan_in  = last_chan ? CH_RED : chan_ff + 2'd1;
         end
         ST_AC_RD:  state_in = ST_AC_MAC;
         ST_AC_MAC: begin
            state_in = last_chan ? ST_CMP_MUL : ST_AC_RD;
            chan_in  = last_chan ? CH_RED : chan_ff + 2'd1;
         end
         ST_CMP_MUL: state_in = ST_DECIDE;
         ST_DECIDE: begin
            chan_in  = CH_RED;
            state_in = (status.below && status.more_steps) ? ST_BLEND : ST_TXT;
         end
         ST_BLEND: begin
            state_in = last_chan ? ST_AC_RD : ST_BLEND;
            chan_in  = last_chan ? CH_RED : chan_ff + 2'd1;
         end
         ST_TXT:  state_in = ST_DONE;
         ST_DONE: if (!status.out_busy) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      cmd.chan  = chan_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_BK_RD: begin
            cmd.rd       = 1'b1;
            cmd.use_back = 1'b1;
         end
         ST_BK_MAC: begin
            cmd.mac      = 1'b1;
            cmd.use_back = 1'b1;
         end
         ST_AC_RD:   cmd.rd  = 1'b1;
         ST_AC_MAC:  cmd.mac = 1'b1;
         ST_CMP_MUL: cmd.cmp_mul = 1'b1;
         ST_DECIDE:  cmd.finish = !(status.below && status.more_steps);
         ST_BLEND: begin
            cmd.blend    = 1'b1;
            cmd.step_inc = last_chan;
         end
         ST_TXT:  cmd.txt = 1'b1;
         ST_DONE: cmd.out_load = !status.out_busy;
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

### src/cecb_dp.sv
// ----------------------------------------------------------------------------
// cecb_dp
// Datapath: color registers, linearization ROM, luminance MAC, contrast
// compare, blend step and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cecb_dp
   import cecb_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire dp_cmd_type      cmd,
   output      dp_status_type   status,
   input  wire req_payload_type req_word,
   input  wire logic [14:0]     min_contrast,
   input  wire logic [15:0]     blend_amount,
   input  wire logic [5:0]      max_steps,
   input  wire logic            rsp_ready,
   output      logic            rsp_valid,
   output      logic [15:0]     rsp_red,
   output      logic [15:0]     rsp_green,
   output      logic [15:0]     rsp_blue,
   output      logic            rsp_text_black,
   output      logic [5:0]      rsp_steps,
   output      logic            rsp_met
);

   localparam lin_table_type LIN_ROM = build_lin_table();

   logic [CH_BITS-1:0] acc_ff  [3];
   logic [CH_BITS-1:0] back_ff [3];
   logic               dark_ff;
   logic [5:0]         steps_ff;
   logic [15:0]        rom_q_ff;
   logic [31:0]        mac_ff, mac_in;
   logic [15:0]        lum_back_ff, lum_acc_ff;
   logic [28:0]        lhs_ff;
   logic [31:0]        rhs_ff;
   logic               met_ff;
   logic [33:0]        sq_ff;
   logic               out_valid_ff;

   logic [CH_BITS-1:0] rd_chan, cur, new_c;
   logic [15:0]        hi_lum, lo_lum;
   logic [16:0]        hi_off, lo_off, lum_off;
   logic [31:0]        up_prod;
   logic [31:0]        dn_prod;

   // Load widened colors (v * 257 is the byte repeated)
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         acc_ff[0]  <= {req_word.accent_red,   req_word.accent_red};
         acc_ff[1]  <= {req_word.accent_green, req_word.accent_green};
         acc_ff[2]  <= {req_word.accent_blue,  req_word.accent_blue};
         back_ff[0] <= {req_word.back_red,     req_word.back_red};
         back_ff[1] <= {req_word.back_green,   req_word.back_green};
         back_ff[2] <= {req_word.back_blue,    req_word.back_blue};
         dark_ff    <= req_word.dark_mode;
      end else if (cmd.blend) begin
         acc_ff[cmd.chan] <= new_c;
      end
   end

   // Step counter
   always_ff @(posedge clock) begin
      if (cmd.load)          steps_ff <= '0;
      else if (cmd.step_inc) steps_ff <= steps_ff + 6'd1;
   end

   // Linearization ROM, registered read
   assign rd_chan = cmd.use_back ? back_ff[cmd.chan] : acc_ff[cmd.chan];
   always_ff @(posedge clock) begin
      if (cmd.rd) rom_q_ff <= LIN_ROM[rd_chan[CH_BITS-1 -: LUT_INDEX_BITS]];
   end

   // Luminance multiply-accumulate; restarts on red
   assign mac_in = ((cmd.chan == CH_RED) ? 32'd0 : mac_ff)
                 + ({15'd0, lum_weight(cmd.chan)} * {16'd0, rom_q_ff});
   always_ff @(posedge clock) begin
      if (cmd.mac) begin
         mac_ff <= mac_in;
         if (cmd.chan == CH_BLUE) begin
            if (cmd.use_back) lum_back_ff <= mac_in[31:16];
            else              lum_acc_ff  <= mac_in[31:16];
         end
      end
   end

   // Contrast products
   assign hi_lum = (lum_acc_ff > lum_back_ff) ? lum_acc_ff : lum_back_ff;
   assign lo_lum = (lum_acc_ff > lum_back_ff) ? lum_back_ff : lum_acc_ff;
   assign hi_off = {1'b0, hi_lum} + LUM_OFFSET;
   assign lo_off = {1'b0, lo_lum} + LUM_OFFSET;
   always_ff @(posedge clock) begin
      if (cmd.cmp_mul) begin
         lhs_ff <= {hi_off, 12'd0};
         rhs_ff <= {17'd0, min_contrast} * {15'd0, lo_off};
      end
   end

   assign status.below      = {3'd0, lhs_ff} < rhs_ff;
   assign status.more_steps = steps_ff < max_steps;
   assign status.out_busy   = out_valid_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.finish) met_ff <= !status.below;
   end

   // Blend step toward white or black
   assign cur     = acc_ff[cmd.chan];
   assign up_prod = {16'd0, 16'hFFFF - cur} * {16'd0, blend_amount};
   assign dn_prod = ({16'd0, cur} * {16'd0, blend_amount}) + 32'd65535;
   assign new_c   = dark_ff ? cur + up_prod[31:16] : cur - dn_prod[31:16];

   // Text choice square
   assign lum_off = {1'b0, lum_acc_ff} + LUM_OFFSET;
   always_ff @(posedge clock) begin
      if (cmd.txt) sq_ff <= {17'd0, lum_off} * {17'd0, lum_off};
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_red        <= acc_ff[0];
         rsp_green      <= acc_ff[1];
         rsp_blue       <= acc_ff[2];
         rsp_text_black <= sq_ff > TEXT_LIMIT;
         rsp_steps      <= steps_ff;
         rsp_met        <= met_ff;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

`default_nettype wire

### src/contrast_enforcing_color_blend.sv
// ----------------------------------------------------------------------------
// contrast_enforcing_color_blend
// Moves an accent color toward white or black until it contrasts enough
// with a background, then picks black or white text for it.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one word: accent RGB, background RGB, dark_mode.
//   rsp_bus returns one word per request: blended RGB (Q0.16), text choice,
//   step count and met flag. csr_bus writes min_contrast (0),
//   blend_amount (1), max_steps (2); other indexes are dropped. csr ready
//   is always high; write only while no request is in flight.
// Sequence: background luminance pass, then for each contrast check an
//   accent luminance pass and the compare, and for each blend step the
//   blend of each channel and the recheck; then the text square and the
//   output register load. The passes share one luminance MAC and a
//   single-port ROM. One request at a time; the next can be taken as soon
//   as the result is in the output register.
// Reset: registers return to 3.0, 0.06 and 20; the sequencer idles and
//   the output register empties.
// Stall: a held result stays in the output register; the sequencer takes
//   the next request meanwhile but waits in its last state, with request
//   ready low, until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module contrast_enforcing_color_blend
   import cecb_pkg::*;
(
   input wire logic  clock,
   input wire logic  reset,
   cecb_req_if.sink  req_bus,
   cecb_rsp_if.source rsp_bus,
   cecb_csr_if.sink  csr_bus
);

   logic [14:0]     min_contrast_ff;
   logic [15:0]     blend_amount_ff;
   logic [5:0]      max_steps_ff;
   dp_cmd_type      cmd;
   dp_status_type   status;
   req_payload_type req_word;

   // Configuration registers
   assign csr_bus.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         min_contrast_ff <= MIN_CONTRAST_RST;
         blend_amount_ff <= BLEND_AMOUNT_RST;
         max_steps_ff    <= MAX_STEPS_RST;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_MIN_CONTRAST: min_contrast_ff <= csr_bus.data[14:0];
            CSR_BLEND_AMOUNT: blend_amount_ff <= csr_bus.data;
            CSR_MAX_STEPS:    max_steps_ff    <= csr_bus.data[5:0];
            default: ;
         endcase
      end
   end

   assign req_word = '{accent_red:   req_bus.accent_red,
                       accent_green: req_bus.accent_green,
                       accent_blue:  req_bus.accent_blue,
                       back_red:     req_bus.back_red,
                       back_green:   req_bus.back_green,
                       back_blue:    req_bus.back_blue,
                       dark_mode:    req_bus.dark_mode};

   cecb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cecb_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_word       (req_word),
      .min_contrast   (min_contrast_ff),
      .blend_amount   (blend_amount_ff),
      .max_steps      (max_steps_ff),
      .rsp_ready      (rsp_bus.ready),
      .rsp_valid      (rsp_bus.valid),
      .rsp_red        (rsp_bus.sel_red),
      .rsp_green      (rsp_bus.sel_green),
      .rsp_blue       (rsp_bus.sel_blue),
      .rsp_text_black (rsp_bus.text_is_black),
      .rsp_steps      (rsp_bus.blend_steps),
      .rsp_met        (rsp_bus.contrast_met)
   );

   // A taken request leaves the sequencer busy
   assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready)
      else $error("request taken while busy");

   // Step count never passes the limit
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.blend_steps <= max_steps_ff)
      else $error("step count over limit");

   // Unmet contrast only after all steps are spent
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.contrast_met |-> rsp_bus.blend_steps == max_steps_ff)
      else $error("gave up before the step limit");

endmodule

`default_nettype wire

### tb/cecb_tb_if.sv
// ----------------------------------------------------------------------------
// cecb_tb_if
// Testbench-side type for the response channel.
// The block's own interfaces are used directly; this file only holds the
// word type for the predicted results.
// ----------------------------------------------------------------------------
`default_nettype none

package cecb_tb_pkg;
   import cecb_pkg::*;

   // One expected result word
   typedef struct packed {
      logic [15:0] sel_red;
      logic [15:0] sel_green;
      logic [15:0] sel_blue;
      logic        text_is_black;
      logic [5:0]  blend_steps;
      logic        contrast_met;
   } blend_result_type;
endpackage

`default_nettype wire

### tb/tb_contrast_enforcing_color_blend.sv
// ----------------------------------------------------------------------------
// tb_contrast_enforcing_color_blend
// Drives color words through the blend block under random idling and a long
// response hold-off, predicts each result in fixed point and compares fields.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_contrast_enforcing_color_blend
   import cecb_pkg::*, cecb_tb_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 5000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cecb_req_if req_bus ();
   cecb_rsp_if rsp_bus ();
   cecb_csr_if csr_bus ();

   contrast_enforcing_color_blend u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source),
      .csr_bus(csr_bus.sink)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predictor state: registers and linearization table
   logic [15:0] lin_lut [LUT_SIZE];
   logic [14:0] cfg_min_contrast = MIN_CONTRAST_RST;
   logic [15:0] cfg_blend_amount = BLEND_AMOUNT_RST;
   logic [5:0]  cfg_max_steps    = MAX_STEPS_RST;

   req_payload_type  color_words [$];
   blend_result_type expected_blends [$];

   int unsigned cycles = 0;
   int unsigned mismatches = 0;
   int unsigned words_sent = 0;
   int unsigned words_checked = 0;
   bit          quiet_idle = 1'b0;
   bit          hold_rsp = 1'b0;

   // Table entry i: sRGB x to linear, fifth root by bisection
   function automatic logic [15:0] lin_value(int i);
      longint unsigned x, t, tt, n, lo, hi, mid, p;
      x = (longint'(i) * 65535) / longint'(LUT_SIZE - 1);
      if (x <= 2574) return 16'((x * 100) / 1292);
      t  = (1000 * x + 3604480) / 1055;
      tt = t >> 2;
      n  = (tt * tt) << 32;
      lo = 0;
      hi = 4096;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         p = mid * mid * mid * mid * mid;
         if (p <= n) lo = mid;
         else hi = mid - 1;
      end
      return 16'((t * t * lo) >> 28);
   endfunction

   function automatic longint unsigned rel_lum(input logic [15:0] c [3]);
      longint unsigned s;
      s = 13933 * longint'(lin_lut[c[0] >> LUT_SHIFT])
        + 46871 * longint'(lin_lut[c[1] >> LUT_SHIFT])
        + 4732  * longint'(lin_lut[c[2] >> LUT_SHIFT]);
      return s >> 16;
   endfunction

   function automatic bit too_low(input logic [15:0] a [3], input logic [15:0] b [3]);
      longint unsigned la, lb, hi, lo;
      la = rel_lum(a);
      lb = rel_lum(b);
      hi = (la > lb) ? la : lb;
      lo = (la > lb) ? lb : la;
      return (hi + 3277) * 4096 < longint'(cfg_min_contrast) * (lo + 3277);
   endfunction

   function automatic blend_result_type blend_color(req_payload_type w);
      blend_result_type r;
      logic [15:0] acc [3];
      logic [15:0] bg [3];
      longint unsigned c, tgt, l;
      int steps;
      acc[0] = 16'(w.accent_red * 257);
      acc[1] = 16'(w.accent_green * 257);
      acc[2] = 16'(w.accent_blue * 257);
      bg[0]  = 16'(w.back_red * 257);
      bg[1]  = 16'(w.back_green * 257);
      bg[2]  = 16'(w.back_blue * 257);
      tgt = w.dark_mode ? 65535 : 0;
      steps = 0;
      while (steps < cfg_max_steps && too_low(acc, bg)) begin
         for (int k = 0; k < 3; k++) begin
            c = acc[k];
            if (tgt >= c) c = c + (((tgt - c) * cfg_blend_amount) >> 16);
            else c = c - (((c - tgt) * cfg_blend_amount + 65535) >> 16);
            acc[k] = 16'(c);
         end
         steps++;
      end
      r.contrast_met = !too_low(acc, bg);
      l = rel_lum(acc);
      r.text_is_black = ((l + 3277) * (l + 3277)) > 225485783;
      r.sel_red = acc[0];
      r.sel_green = acc[1];
      r.sel_blue = acc[2];
      r.blend_steps = 6'(steps);
      return r;
   endfunction

   // Driver: offers queued words, idles at random
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (req_bus.valid) begin
            expected_blends.push_back(blend_color(req_payload_type'({req_bus.accent_red,
               req_bus.accent_green, req_bus.accent_blue, req_bus.back_red,
               req_bus.back_green, req_bus.back_blue, req_bus.dark_mode})));
            words_sent <= words_sent + 1;
         end
         if (color_words.size() > 0 && (quiet_idle || $urandom_range(99) >= 24)) begin
            req_payload_type w;
            w = color_words.pop_front();
            req_bus.valid        <= 1'b1;
            req_bus.accent_red   <= w.accent_red;
            req_bus.accent_green <= w.accent_green;
            req_bus.accent_blue  <= w.accent_blue;
            req_bus.back_red     <= w.back_red;
            req_bus.back_green   <= w.back_green;
            req_bus.back_blue    <= w.back_blue;
            req_bus.dark_mode    <= w.dark_mode;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Monitor: compares response words and stalls at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            blend_result_type got;
            got = {rsp_bus.sel_red, rsp_bus.sel_green, rsp_bus.sel_blue,
                   rsp_bus.text_is_black, rsp_bus.blend_steps, rsp_bus.contrast_met};
            words_checked <= words_checked + 1;
            if (expected_blends.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10) $display("unexpected response word %h", got);
            end else begin
               blend_result_type want;
               want = expected_blends.pop_front();
               if (got !== want) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= 10) begin
                     $display("mismatch: exp rgb %h %h %h txt %b st %0d met %b",
                        want.sel_red, want.sel_green, want.sel_blue, want.text_is_black,
                        want.blend_steps, want.contrast_met);
                     $display("          got rgb %h %h %h txt %b st %0d met %b",
                        got.sel_red, got.sel_green, got.sel_blue, got.text_is_black,
                        got.blend_steps, got.contrast_met);
                  end
               end
            end
         end
         rsp_bus.ready <= !hold_rsp && (quiet_idle || $urandom_range(99) >= 24);
      end
   end

   // Timeout
   always @(posedge clock) begin
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL");
         $finish;
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (idx)
         CSR_MIN_CONTRAST: cfg_min_contrast = value[14:0];
         CSR_BLEND_AMOUNT: cfg_blend_amount = value;
         CSR_MAX_STEPS:    cfg_max_steps = value[5:0];
         default: ;
      endcase
   endtask

   // Wait until the last queued word is offered, taken and answered
   task automatic drain();
      while (color_words.size() > 0) @(posedge clock);
      @(posedge clock);
      while (req_bus.valid || expected_blends.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic req_payload_type rand_word();
      req_payload_type w;
      w = req_payload_type'(49'({$urandom, $urandom}));
      return w;
   endfunction

   task automatic queue_colors(input int count);
      req_payload_type w;
      for (int i = 0; i < count; i++) begin
         w = rand_word();
         // bias toward near-matching pairs so blending runs many steps
         if ($urandom_range(3) == 0) begin
            w.back_red = w.accent_red ^ 8'($urandom_range(15));
            w.back_green = w.accent_green ^ 8'($urandom_range(15));
            w.back_blue = w.accent_blue ^ 8'($urandom_range(15));
         end
         color_words.push_back(w);
      end
   endtask

   initial begin
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_MIN_CONTRAST;
      csr_bus.data = '0;
      for (int i = 0; i < LUT_SIZE; i++) lin_lut[i] = lin_value(i);
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, both modes, identical colors
      for (int m = 0; m < 2; m++) begin
         color_words.push_back({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'(m)});
         color_words.push_back({8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 1'(m)});
         color_words.push_back({8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 1'(m)});
         color_words.push_back({8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 1'(m)});
         color_words.push_back({8'h80, 8'h80, 8'h80, 8'h7f, 8'h7f, 8'h7f, 1'(m)});
         color_words.push_back({8'hff, 8'h00, 8'haa, 8'h55, 8'hff, 8'h01, 1'(m)});
      end
      drain();

      // Zero steps, zero blend amount, low threshold, top threshold, dropped index
      write_reg(CSR_MAX_STEPS, 16'd0);
      queue_colors(6);
      drain();
      write_reg(CSR_MAX_STEPS, 16'd63);
      write_reg(CSR_BLEND_AMOUNT, 16'd0);
      write_reg(CSR_MIN_CONTRAST, 16'd32767);
      queue_colors(4);
      drain();
      write_reg(CSR_MIN_CONTRAST, 16'd100);
      write_reg(CSR_BLEND_AMOUNT, 16'd65535);
      write_reg(2'd3, 16'hffff);
      queue_colors(4);
      drain();

      // Back-pressure: hold responses while words keep coming
      write_reg(CSR_MIN_CONTRAST, 16'd32767);
      write_reg(CSR_BLEND_AMOUNT, 16'd1);
      hold_rsp = 1'b1;
      queue_colors(30);
      repeat (3000) @(posedge clock);
      hold_rsp = 1'b0;
      drain();

      // Random phases over several settings; one phase without idling
      for (int ph = 0; ph < 8; ph++) begin
         write_reg(CSR_MIN_CONTRAST, 16'($urandom_range(32767, 4096)));
         write_reg(CSR_BLEND_AMOUNT, 16'($urandom_range(65535, 1)));
         write_reg(CSR_MAX_STEPS, 16'($urandom_range(63)));
         if (ph == 5) write_reg(CSR_MAX_STEPS, 16'd20);
         quiet_idle = (ph == 3);
         queue_colors(100);
         drain();
      end
      quiet_idle = 1'b0;

      $display("covered %0d words checked, %0d sent, over register extremes and random settings",
               words_checked, words_sent);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
